@@ hw/rtl/tbps_pkg.sv @@
// Shared types and constants for the token bucket packet shaper.
// Depends on nothing; imported by the interfaces, refill divider, top level and bench.
package tbps_pkg;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int LEN_W    = 16;
  localparam int TAG_W    = 32;
  localparam int MS_W     = 16;
  localparam int OUTC_W   = 2;
  localparam int RATE_W   = 24;
  localparam int QLIM_W   = 7;
  localparam int QUOTA_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b1;

  // Reset values
  localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd4000;
  localparam logic [QLIM_W-1:0]  QLIM_RESET  = 7'd64;
  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 32'd4000;

  // Queue sizing
  localparam int QUEUE_DEPTH_DEF = 64;

  // Commands and outcomes
  localparam logic [CMD_W-1:0]  CMD_SEND  = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_TICK  = 1'b1;
  localparam logic [OUTC_W-1:0] OUTCOME_FORWARDED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTCOME_QUEUED    = 2'd1;
  localparam logic [OUTC_W-1:0] OUTCOME_DROPPED   = 2'd2;

  // Refill divider: rate * ms / 1000 as (rate * ms) * RECIP_1000 >> RECIP_SHIFT
  localparam int PROD_W      = RATE_W + MS_W;   // 40-bit exact product
  localparam int QUOT_W      = 31;              // 2^40 / 1000 < 2^31
  localparam int HALF_W      = PROD_W / 2;      // product taken in two 20-bit halves
  localparam int RECIP_W     = 41;
  localparam int RECIP_LO_W  = 21;              // low part of the reciprocal
  localparam int RECIP_SHIFT = 50;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 41'd1125899906843;  // ceil(2^50 / 1000)
  localparam int MUL_A_W     = RATE_W;
  localparam int MUL_B_W     = RECIP_LO_W;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int PP_W        = HALF_W + RECIP_LO_W;
  localparam int ACC_W       = PROD_W + RECIP_W;
  localparam int PP_STEPS    = 4;
  localparam int STEP_W      = 3;

  // One queued descriptor
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } queue_entry_t;

endpackage

@@ hw/rtl/tbps_if.sv @@
// Request and result channel interfaces for the packet shaper.
// Depends on tbps_pkg for field widths.
interface tbps_in_if import tbps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LEN_W-1:0]  packet_length;
  logic [TAG_W-1:0]  packet_tag;
  logic              no_drop;
  logic [MS_W-1:0]   elapsed_ms;

  modport source (output valid, command, packet_length, packet_tag, no_drop, elapsed_ms,
                  input ready);
  modport sink   (input valid, command, packet_length, packet_tag, no_drop, elapsed_ms,
                  output ready);
endinterface

interface tbps_out_if import tbps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] outcome;
  logic [LEN_W-1:0]  out_length;
  logic [TAG_W-1:0]  out_tag;
  logic              last_of_run;

  modport source (output valid, outcome, out_length, out_tag, last_of_run, input ready);
  modport sink   (input valid, outcome, out_length, out_tag, last_of_run, output ready);
endinterface

@@ hw/rtl/tbps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the descriptor queue.
module tbps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tbps_refill_div.sv @@
// Refill amount unit: rate * ms product, then division by 1000 as a multiply by the
// reciprocal, built from four partial products on one shared multiplier. Depends on tbps_pkg.
module tbps_refill_div import tbps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RATE_W-1:0] rate,
  input  logic [MS_W-1:0]   ms,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  // Partial product weights; step k of the sequence produces weight k
  localparam logic [1:0] W_LL = 2'd0;   // low half * low reciprocal, shift 0
  localparam logic [1:0] W_HL = 2'd1;   // high half * low reciprocal, shift HALF_W
  localparam logic [1:0] W_LH = 2'd2;   // low half * high reciprocal, shift RECIP_LO_W
  localparam logic [1:0] W_HH = 2'd3;   // high half * high reciprocal, shift both

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PP_STEPS);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [PP_W-1:0]    pp_r, pp_nxt;
  logic [1:0]         sh_r, sh_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [ACC_W-1:0]   pp_shifted;

  // Shared multiplier: rate * ms on start, then one partial product per step
  always_comb begin
    mul_a = MUL_A_W'(prod_r[HALF_W-1:0]);
    mul_b = RECIP_1000[RECIP_LO_W-1:0];
    if (start) begin
      mul_a = rate;
      mul_b = MUL_B_W'(ms);
    end else begin
      case (step_r[1:0])
        W_LL: begin
          mul_a = MUL_A_W'(prod_r[HALF_W-1:0]);
          mul_b = RECIP_1000[RECIP_LO_W-1:0];
        end
        W_HL: begin
          mul_a = MUL_A_W'(prod_r[PROD_W-1:HALF_W]);
          mul_b = RECIP_1000[RECIP_LO_W-1:0];
        end
        W_LH: begin
          mul_a = MUL_A_W'(prod_r[HALF_W-1:0]);
          mul_b = MUL_B_W'(RECIP_1000[RECIP_W-1:RECIP_LO_W]);
        end
        default: begin
          mul_a = MUL_A_W'(prod_r[PROD_W-1:HALF_W]);
          mul_b = MUL_B_W'(RECIP_1000[RECIP_W-1:RECIP_LO_W]);
        end
      endcase
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // Align the registered partial product to its weight
  always_comb begin
    case (sh_r)
      W_LL:    pp_shifted = ACC_W'(pp_r);
      W_HL:    pp_shifted = ACC_W'(pp_r) << HALF_W;
      W_LH:    pp_shifted = ACC_W'(pp_r) << RECIP_LO_W;
      default: pp_shifted = ACC_W'(pp_r) << (HALF_W + RECIP_LO_W);
    endcase
  end

  // Sequencer: four products, each registered and then added to the accumulator
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    prod_nxt = prod_r;
    pp_nxt   = pp_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      prod_nxt = mul_p[PROD_W-1:0];
      acc_nxt  = '0;
    end else if (busy_r) begin
      pp_nxt   = mul_p[PP_W-1:0];
      sh_nxt   = step_r[1:0];
      step_nxt = step_r + 1'b1;
      if (step_r != '0) begin
        acc_nxt = acc_r + pp_shifted;
      end
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    pp_r   <= pp_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
  end

  assign done     = done_r;
  assign quotient = acc_r[ACC_W-1:RECIP_SHIFT];

endmodule

@@ hw/rtl/token_bucket_packet_shaper_unit.sv @@
// Token bucket packet shaper, top level.
// Send: accepted when idle, result valid the next cycle; no new request is accepted
// until the result is taken. Tick: refill (product, four reciprocal partial products
// for the divide by 1000, add) when quota < rate, then queued packets that fit go out.
// Synchronous active-low reset: quota 4000, rate 4000, queue limit 64, queue empty.
// Queue storage is not cleared; entries are only read after being written.
module token_bucket_packet_shaper_unit import tbps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tbps_in_if.sink               in_chan,
  tbps_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OUT  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DCK  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic               ret_idle_r, ret_idle_nxt;
  logic [QUOTA_W-1:0] quota_r, quota_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [RATE_W-1:0]  rate_r;
  logic [QLIM_W-1:0]  qlim_r;

  logic               out_valid_r, out_valid_nxt;
  logic [OUTC_W-1:0]  out_outcome_r, out_outcome_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_last_r, out_last_nxt;

  logic               pend_valid_r, pend_valid_nxt;
  logic [LEN_W-1:0]   pend_len_r, pend_len_nxt;
  logic [TAG_W-1:0]   pend_tag_r, pend_tag_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  queue_entry_t       ram_wdata, ram_rdata;

  logic               div_start, div_done;
  logic [QUOT_W-1:0]  div_quot;

  logic               in_acc;
  logic [SUM_W-1:0]   slot_sum;
  logic [IDX_W-1:0]   head_inc;
  logic [QUOTA_W:0]   refill_sum;
  logic               q_full, q_over_lim;

  // Refill amount unit
  tbps_refill_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rate     (rate_r),
    .ms       (in_chan.elapsed_ms),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Descriptor queue storage
  tbps_ram #(
    .WIDTH ($bits(queue_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && (state_r == S_IDLE);

  // Tail slot, head advance, queue occupancy checks, refill sum
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    ram_waddr = slot_sum[IDX_W-1:0];
    head_inc  = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    q_full     = (count_r == CNT_W'(QUEUE_DEPTH));
    q_over_lim = (QLIM_W'(count_r) >= qlim_r);
    refill_sum = {1'b0, quota_r} + (QUOTA_W + 1)'(div_quot);
    ram_wdata.len = in_chan.packet_length;
    ram_wdata.tag = in_chan.packet_tag;
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    ret_idle_nxt    = ret_idle_r;
    quota_nxt       = quota_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_len_nxt     = out_len_r;
    out_tag_nxt     = out_tag_r;
    out_last_nxt    = out_last_r;
    pend_valid_nxt  = pend_valid_r;
    pend_len_nxt    = pend_len_r;
    pend_tag_nxt    = pend_tag_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    div_start       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.command == CMD_SEND) begin
            out_valid_nxt = 1'b1;
            out_len_nxt   = in_chan.packet_length;
            out_tag_nxt   = in_chan.packet_tag;
            out_last_nxt  = 1'b1;
            ret_idle_nxt  = 1'b1;
            state_nxt     = S_OUT;
            if (quota_r >= QUOTA_W'(in_chan.packet_length)) begin
              quota_nxt       = quota_r - QUOTA_W'(in_chan.packet_length);
              out_outcome_nxt = OUTCOME_FORWARDED;
            end else if ((q_over_lim && !in_chan.no_drop) || q_full) begin
              out_outcome_nxt = OUTCOME_DROPPED;
            end else begin
              ram_we          = 1'b1;
              count_nxt       = count_r + 1'b1;
              out_outcome_nxt = OUTCOME_QUEUED;
            end
          end else begin
            pend_valid_nxt = 1'b0;
            if (quota_r < QUOTA_W'(rate_r)) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_DRD;
            end
          end
        end
      end

      // Hold the result until the sink takes it
      S_OUT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ret_idle_r ? S_IDLE : S_DRD;
        end
      end

      // Wait for the refill amount, then add with saturation
      S_DIV: begin
        if (div_done) begin
          quota_nxt = refill_sum[QUOTA_W] ? '1 : refill_sum[QUOTA_W-1:0];
          state_nxt = S_DRD;
        end
      end

      // Read the head entry, or flush the held packet as last of run
      S_DRD: begin
        if (count_r == '0) begin
          if (pend_valid_r) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUTCOME_FORWARDED;
            out_len_nxt     = pend_len_r;
            out_tag_nxt     = pend_tag_r;
            out_last_nxt    = 1'b1;
            pend_valid_nxt  = 1'b0;
            ret_idle_nxt    = 1'b1;
            state_nxt       = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DCK;
        end
      end

      // Head fits: take it and pass on the previous one; else close the run
      S_DCK: begin
        if (QUOTA_W'(ram_rdata.len) <= quota_r) begin
          quota_nxt      = quota_r - QUOTA_W'(ram_rdata.len);
          head_nxt       = head_inc;
          count_nxt      = count_r - 1'b1;
          pend_valid_nxt = 1'b1;
          pend_len_nxt   = ram_rdata.len;
          pend_tag_nxt   = ram_rdata.tag;
          if (pend_valid_r) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUTCOME_FORWARDED;
            out_len_nxt     = pend_len_r;
            out_tag_nxt     = pend_tag_r;
            out_last_nxt    = 1'b0;
            ret_idle_nxt    = 1'b0;
            state_nxt       = S_OUT;
          end else begin
            state_nxt = S_DRD;
          end
        end else if (pend_valid_r) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = OUTCOME_FORWARDED;
          out_len_nxt     = pend_len_r;
          out_tag_nxt     = pend_tag_r;
          out_last_nxt    = 1'b1;
          pend_valid_nxt  = 1'b0;
          ret_idle_nxt    = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_idle_r   <= 1'b1;
      quota_r      <= QUOTA_RESET;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      rate_r       <= RATE_RESET;
      qlim_r       <= QLIM_RESET;
    end else begin
      state_r      <= state_nxt;
      ret_idle_r   <= ret_idle_nxt;
      quota_r      <= quota_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RATE_LIMIT:  rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_QUEUE_LIMIT: qlim_r <= cfg_wdata[QLIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_outcome_r <= out_outcome_nxt;
    out_len_r     <= out_len_nxt;
    out_tag_r     <= out_tag_nxt;
    out_last_r    <= out_last_nxt;
    pend_len_r    <= pend_len_nxt;
    pend_tag_r    <= pend_tag_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.outcome     = out_outcome_r;
  assign out_chan.out_length  = out_len_r;
  assign out_chan.out_tag     = out_tag_r;
  assign out_chan.last_of_run = out_last_r;

endmodule

@@ bench/tbps_shaper_checker.sv @@
// Scoreboard for the packet shaper: watches both channels and the register port,
// predicts every result and compares it field by field.
// Depends on tbps_pkg and the channel interfaces in tbps_if.sv.
module tbps_shaper_checker import tbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tbps_in_if                    in_mon,
  tbps_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } shaped_result_t;

  // Shadow registers and bucket state
  logic [RATE_W-1:0]  rate_q;
  logic [QLIM_W-1:0]  qlim_q;
  logic [QUOTA_W-1:0] quota_q;
  queue_entry_t       backlog[$];
  shaped_result_t     expected_q[$];
  int                 errors = 0;

  // Spend quota on one request, or refill and drain the backlog on a tick
  task automatic shape_request(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] pkt_len,
                               input logic [TAG_W-1:0] pkt_tag, input logic keep,
                               input logic [MS_W-1:0] ms);
    logic [63:0]    refilled;
    int             drained;
    shaped_result_t r;
    queue_entry_t   entry;
    drained = 0;
    if (cmd == CMD_SEND) begin
      r.length = pkt_len;
      r.tag    = pkt_tag;
      r.last   = 1'b1;
      if (quota_q >= QUOTA_W'(pkt_len)) begin
        quota_q   = quota_q - QUOTA_W'(pkt_len);
        r.outcome = OUTCOME_FORWARDED;
      end else if ((backlog.size() >= int'(qlim_q) && !keep) ||
                   backlog.size() >= QUEUE_DEPTH_DEF) begin
        r.outcome = OUTCOME_DROPPED;
      end else begin
        entry.tag = pkt_tag;
        entry.len = pkt_len;
        backlog.insert(backlog.size(), entry);
        r.outcome = OUTCOME_QUEUED;
      end
      expected_q.insert(expected_q.size(), r);
    end else begin
      // refill only below the rate; exact product, truncating divide, saturating sum
      if (quota_q < QUOTA_W'(rate_q)) begin
        refilled = 64'(quota_q) + (64'(rate_q) * 64'(ms)) / 64'd1000;
        quota_q  = (refilled > 64'hFFFF_FFFF) ? '1 : refilled[QUOTA_W-1:0];
      end
      while (backlog.size() > 0 && drained < QUEUE_DEPTH_DEF &&
             QUOTA_W'(backlog[0].len) <= quota_q) begin
        quota_q = quota_q - QUOTA_W'(backlog[0].len);
        r = '{outcome: OUTCOME_FORWARDED, length: backlog[0].len, tag: backlog[0].tag,
              last: 1'b0};
        backlog.delete(0);
        expected_q.insert(expected_q.size(), r);
        drained++;
      end
      if (drained > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    end
  endtask

  // Compare one accepted result against the oldest expectation
  task automatic check_result();
    shaped_result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: outcome %0d length %0d tag %h", out_mon.outcome,
             out_mon.out_length, out_mon.out_tag);
      errors++;
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      if (out_mon.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, out_mon.outcome);
        errors++;
      end
      if (out_mon.out_length !== want.length) begin
        $error("out_length: expected %0d, got %0d", want.length, out_mon.out_length);
        errors++;
      end
      if (out_mon.out_tag !== want.tag) begin
        $error("out_tag: expected %h, got %h", want.tag, out_mon.out_tag);
        errors++;
      end
      if (out_mon.last_of_run !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, out_mon.last_of_run);
        errors++;
      end
    end
  endtask

  // Results are checked before the same edge's request is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      rate_q  = RATE_RESET;
      qlim_q  = QLIM_RESET;
      quota_q = QUOTA_RESET;
      backlog.delete();
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) begin
        if (cfg_index == CFG_RATE_LIMIT) begin
          rate_q = cfg_wdata[RATE_W-1:0];
        end else begin
          qlim_q = cfg_wdata[QLIM_W-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        shape_request(in_mon.command, in_mon.packet_length, in_mon.packet_tag,
                      in_mon.no_drop, in_mon.elapsed_ms);
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the packet shaper bench: clock, reset, request stimulus, result back-pressure,
// register writes and the verdict.
// Depends on tbps_pkg, tbps_if.sv, the shaper RTL and tbps_shaper_checker.
module tb_top import tbps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int DRAIN_WAIT  = 80;    // covers a full refill plus one drain check

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    sender_idle_odds;
  int                    stall_odds;
  int                    quiet_cycles = 0;

  tbps_in_if  req_if();
  tbps_out_if res_if();

  token_bucket_packet_shaper_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tbps_shaper_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (req_if),
    .out_mon    (res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Offer one request and hold it until accepted; maybe idle afterwards
  task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] pkt_len,
                              input logic [TAG_W-1:0] pkt_tag, input logic keep,
                              input logic [MS_W-1:0] ms);
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.packet_length <= pkt_len;
    req_if.packet_tag    <= pkt_tag;
    req_if.no_drop       <= keep;
    req_if.elapsed_ms    <= ms;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (sender_idle_odds > 0 && $urandom_range(0, 99) < sender_idle_odds) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Mostly short packets and short ticks, now and then the full range
  task automatic random_request(input int tick_pct);
    logic [LEN_W-1:0] pkt_len;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      pkt_len = LEN_W'($urandom_range(0, 1500));
    end else if (pick < 90) begin
      pkt_len = LEN_W'($urandom_range(1500, 20000));
    end else begin
      pkt_len = LEN_W'($urandom);
    end
    if ($urandom_range(0, 99) < tick_pct) begin
      push_request(CMD_TICK, LEN_W'($urandom), $urandom, 1'($urandom),
                   ($urandom_range(0, 9) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 40)));
    end else begin
      push_request(CMD_SEND, pkt_len, $urandom, 1'($urandom), MS_W'($urandom));
    end
  endtask

  task automatic run_random(input int count, input int tick_pct, input int idle_pct,
                            input int stall_pct);
    sender_idle_odds = idle_pct;
    stall_odds       = stall_pct;
    repeat (count) random_request(tick_pct);
  endtask

  // Stop offering, wait for every expected result, then let a silent tick finish
  task automatic quiesce();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges while the block is idle
  task automatic apply_shaping(input logic [RATE_W-1:0] rate, input logic [QLIM_W-1:0] qlim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RATE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_index <= CFG_QUEUE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(qlim);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_RATE_LIMIT;
    cfg_wdata            = '0;
    req_if.valid         = 1'b0;
    req_if.command       = CMD_SEND;
    req_if.packet_length = '0;
    req_if.packet_tag    = '0;
    req_if.no_drop       = 1'b0;
    req_if.elapsed_ms    = '0;
    res_if.ready         = 1'b1;
    sender_idle_odds     = 20;
    stall_odds           = 15;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset quota is 4000: zero length and exact fit both go out
    push_request(CMD_SEND, 16'd0, 32'h0000_0000, 1'b0, 16'hFFFF);
    push_request(CMD_SEND, 16'd4000, 32'hFFFF_FFFF, 1'b1, 16'h0000);
    // bucket empty: these wait in the backlog
    push_request(CMD_SEND, 16'hFFFF, 32'h5A5A_A5A5, 1'b0, 16'd0);
    push_request(CMD_SEND, 16'd1, 32'hA5A5_5A5A, 1'b1, 16'd0);
    // zero elapsed time adds nothing, head does not fit, no result
    push_request(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'd0);
    // fill the backlog to its depth
    repeat (QUEUE_DEPTH_DEF - 2) begin
      push_request(CMD_SEND, LEN_W'($urandom_range(1, 2000)), $urandom, 1'($urandom),
                   MS_W'($urandom));
    end
    // droppable send refused at the limit; protected send refused by the full backlog
    push_request(CMD_SEND, 16'd20, 32'h1234_5678, 1'b0, 16'd0);
    push_request(CMD_SEND, 16'd20, 32'h8765_4321, 1'b1, 16'd0);
    // longest tick refills enough to drain all of it in one run
    push_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 16'hFFFF);
    // quota now above the rate: no refill, nothing queued
    push_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 16'd1);
    quiesce();

    // widest rate, zero limit: every droppable miss is dropped
    apply_shaping(24'hFF_FFFF, 7'd0);
    repeat (5) push_request(CMD_SEND, 16'hFFFF, $urandom, 1'b0, 16'd0);
    push_request(CMD_SEND, 16'hFFFF, 32'hCAFE_0001, 1'b1, 16'd0);
    push_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 16'd1);
    push_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 16'd4);
    quiesce();

    // no refill and a limit above the depth: backlog fills to the brim
    apply_shaping(24'd0, 7'd127);
    run_random(90, 10, 20, 15);
    quiesce();

    apply_shaping(24'd4000, 7'd64);
    run_random(25, 30, 0, 0);
    quiesce();

    apply_shaping(24'd1000, 7'd8);
    run_random(25, 25, 30, 30);
    quiesce();

    apply_shaping(24'd50000, 7'd2);
    run_random(25, 25, 15, 25);
    quiesce();

    apply_shaping(24'd1, 7'd0);
    run_random(30, 25, 20, 10);
    quiesce();

    apply_shaping(RATE_W'($urandom_range(0, 200000)), QLIM_W'($urandom_range(0, 127)));
    run_random(25, 25, 20, 20);
    quiesce();

    // closing stretch at full rate without idling, ending on the largest refill
    apply_shaping(24'hFF_FFFF, 7'd64);
    run_random(25, 25, 0, 0);
    push_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 16'hFFFF);
    quiesce();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tbps_pkg.sv
hw/rtl/tbps_if.sv
hw/rtl/tbps_ram.sv
hw/rtl/tbps_refill_div.sv
hw/rtl/token_bucket_packet_shaper_unit.sv
bench/tbps_shaper_checker.sv
bench/tb_top.sv
